FILE: design/extent_map_read_macros.svh
// assertion macros shared by the extent map read design
// no dependencies; included by the modules that carry assertions
`ifndef EXTENT_MAP_READ_MACROS_SVH
`define EXTENT_MAP_READ_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define EMR_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define EMR_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/emr_pkg.sv
// shared types, codes and field positions of the extent map read block
// no dependencies; imported by emr_alu and extent_map_read
`default_nettype none

package emr_pkg;

    // field widths
    localparam int ADDR_W = 48;
    localparam int ROOM_W = 7;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;

    // parameter defaults
    localparam int TABLE_DEPTH_DEF  = 256;
    localparam int MAX_SEGMENTS_DEF = 64;

    // input beat layout
    localparam int S_TUSER_W   = OP_W;
    localparam int IN_ELOG_LSB = 0;
    localparam int IN_EPHY_LSB = ADDR_W;
    localparam int IN_STRT_LSB = 2 * ADDR_W;
    localparam int IN_LEN_LSB  = 3 * ADDR_W;
    localparam int IN_KLIM_LSB = 4 * ADDR_W;
    localparam int IN_ROOM_LSB = 5 * ADDR_W;
    localparam int S_TDATA_W   = ((5 * ADDR_W + ROOM_W + 7) / 8) * 8;

    // output beat layout
    localparam int M_TDATA_W = 4 * ADDR_W;
    localparam int M_TUSER_W = 2 + STAT_W;

    typedef logic [ADDR_W-1:0] addr_t;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    // status codes
    typedef enum logic [STAT_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_BELOW = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SEG_INIT,
        ST_SEG_OFF,
        ST_SEG_SPAN,
        ST_CNT,
        ST_ADV,
        ST_REM,
        ST_KCMP,
        ST_HOLE_CHECK,
        ST_HOLE_SPAN,
        ST_EMIT
    } state_t;

    // kind of result held for the output register
    typedef enum logic [1:0] {
        EMIT_STATUS,
        EMIT_SEG,
        EMIT_HOLE
    } emit_t;

    // one stored extent
    typedef struct packed {
        addr_t logical;
        addr_t physical;
    } entry_t;

    // shared adder request and response
    typedef struct packed {
        addr_t a;
        addr_t b;
        logic  sub;
    } alu_req_t;

    typedef struct packed {
        addr_t sum;
        logic  borrow;
        logic  zero;
    } alu_rsp_t;

endpackage

`default_nettype wire

FILE: design/emr_alu.sv
// shared 48-bit add/subtract unit with borrow and zero flags
// depends on emr_pkg
`default_nettype none

module emr_alu (
    input  emr_pkg::alu_req_t req,
    output emr_pkg::alu_rsp_t rsp
);
    import emr_pkg::*;

    logic [ADDR_W:0] wide_sum;
    addr_t           b_op;

    // subtract as a + ~b + 1, borrow is the missing carry
    assign b_op     = req.sub ? ~req.b : req.b;
    assign wide_sum = {1'b0, req.a} + {1'b0, b_op} + {{ADDR_W{1'b0}}, req.sub};

    assign rsp.sum    = wide_sum[ADDR_W-1:0];
    assign rsp.borrow = req.sub & ~wide_sum[ADDR_W];
    assign rsp.zero   = (wide_sum[ADDR_W-1:0] == '0);

endmodule

`default_nettype wire

FILE: design/extent_map_read.sv
// extent map read: sorted extent table with clear, append and range read
// uses one shared adder (emr_alu) under a sequencer; depends on emr_pkg
// and extent_map_read_macros.svh
//
// Usage: one input beat on s_axis carries an operation in tuser and its
// operands in tdata. Clear, append and undefined operations answer with one
// status beat. A read answers with one beat per segment, tlast on the final
// one, or a single status beat when no segment is produced.
// Input is taken only while the sequencer is idle. A non-read operation
// goes straight to the load step. A read scans the table one entry per
// cycle until the covering entry is found, places the first offset, then
// steps through each segment (compare, clamp, advance, remainder, key
// compare, load); the closing hole takes span, clamp, advance, remainder
// and load, after a hole check when no segment comes before it; one adder
// sets the pace.
// Reset clears the entry count and the sequencer; stored entries are left
// as they are and are never read before being written again.
// Results sit in an output register; a stalled receiver holds the sequencer
// in its load step, and a new item is taken as soon as the final beat of the
// previous one is loaded, even if that beat still waits.
`default_nettype none

`include "extent_map_read_macros.svh"

module extent_map_read #(
    parameter int TABLE_DEPTH  = emr_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_SEGMENTS = emr_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // entry_logical, entry_physical, start_req, length, leaf key bound,
    // segments_free, one pad bit
    input  logic [emr_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // operation
    input  logic [emr_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // seg_length, seg_block, next_start, remaining_length
    output logic [emr_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // seg_valid, hole flag, status
    output logic [emr_pkg::M_TUSER_W-1:0] m_axis_tuser,
    output logic                         m_axis_tlast
);
    import emr_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // extent storage
    entry_t extent_mem [TABLE_DEPTH];
    entry_t rd_entry_reg;
    logic   mem_we;
    entry_t mem_wdata;

    // sequencer and datapath registers
    state_t                state_reg, state_next;
    emit_t                 emit_kind_reg, emit_kind_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [ROOM_W-1:0]     segs_reg, segs_next;
    logic [ROOM_W-1:0]     room_reg, room_next;
    addr_t                 start_reg, start_next;
    addr_t                 len_reg, len_next;
    addr_t                 klim_reg, klim_next;
    addr_t                 phys_reg, phys_next;
    addr_t                 nphys_reg, nphys_next;
    addr_t                 tmp_reg, tmp_next;
    addr_t                 cnt_reg, cnt_next;
    status_t               status_reg, status_next;
    logic                  ltk_reg, ltk_next;

    // output register
    logic                  m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]  m_data_reg, m_data_next;
    logic [M_TUSER_W-1:0]  m_user_reg, m_user_next;
    logic                  m_last_reg, m_last_next;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    // input fields
    logic [OP_W-1:0]   in_op;
    addr_t             in_elog, in_ephy, in_start, in_len, in_klim;
    logic [ROOM_W-1:0] in_room, in_room_clamp;
    logic              in_fire;

    // shared conditions
    logic [CNT_W-1:0]  idx_inc;
    logic [ROOM_W-1:0] segs_inc;
    logic              len_nz, loop_more, hole_more, out_load, table_full;

    emr_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // unpack the input beat
    assign in_op    = s_axis_tuser;
    assign in_elog  = s_axis_tdata[IN_ELOG_LSB +: ADDR_W];
    assign in_ephy  = s_axis_tdata[IN_EPHY_LSB +: ADDR_W];
    assign in_start = s_axis_tdata[IN_STRT_LSB +: ADDR_W];
    assign in_len   = s_axis_tdata[IN_LEN_LSB  +: ADDR_W];
    assign in_klim  = s_axis_tdata[IN_KLIM_LSB +: ADDR_W];
    assign in_room  = s_axis_tdata[IN_ROOM_LSB +: ROOM_W];
    assign in_room_clamp = (in_room > ROOM_W'(MAX_SEGMENTS)) ? ROOM_W'(MAX_SEGMENTS) : in_room;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign idx_inc    = idx_reg + 1'b1;
    assign segs_inc   = segs_reg + 1'b1;
    assign len_nz     = (len_reg != '0);
    assign table_full = (count_reg >= CNT_W'(TABLE_DEPTH));
    assign loop_more  = len_nz && (segs_inc < room_reg) && (idx_inc < count_reg);
    assign hole_more  = ltk_reg && len_nz && (segs_inc < room_reg);
    assign out_load   = (state_reg == ST_EMIT) && (!m_valid_reg || m_axis_tready);

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (in_op != OP_READ) begin
                        state_next = ST_EMIT;
                    end else if (in_room_clamp == '0) begin
                        state_next = ST_EMIT;
                    end else if (count_reg == '0) begin
                        state_next = ST_HOLE_CHECK;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (alu_rsp.zero) begin
                    state_next = (idx_inc < count_reg) ? ST_SEG_INIT : ST_HOLE_CHECK;
                end else if (alu_rsp.borrow) begin
                    state_next = (idx_reg == '0) ? ST_EMIT : ST_SEG_INIT;
                end else if (idx_inc == count_reg) begin
                    state_next = ST_HOLE_CHECK;
                end
            end
            ST_SEG_INIT: state_next = ST_SEG_OFF;
            ST_SEG_OFF:  state_next = ST_SEG_SPAN;
            ST_SEG_SPAN: state_next = ST_CNT;
            ST_CNT:      state_next = ST_ADV;
            ST_ADV:      state_next = ST_REM;
            ST_REM:      state_next = (emit_kind_reg == EMIT_HOLE) ? ST_EMIT : ST_KCMP;
            ST_KCMP:     state_next = ST_EMIT;
            ST_HOLE_CHECK: begin
                state_next = (alu_rsp.borrow && len_nz) ? ST_HOLE_SPAN : ST_EMIT;
            end
            ST_HOLE_SPAN: state_next = ST_CNT;
            ST_EMIT: begin
                if (out_load) begin
                    if (emit_kind_reg == EMIT_SEG && loop_more) begin
                        state_next = ST_SEG_SPAN;
                    end else if (emit_kind_reg == EMIT_SEG && hole_more) begin
                        state_next = ST_HOLE_SPAN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and shared adder control
    always_comb begin
        emit_kind_next = emit_kind_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        segs_next      = segs_reg;
        room_next      = room_reg;
        start_next     = start_reg;
        len_next       = len_reg;
        klim_next      = klim_reg;
        phys_next      = phys_reg;
        nphys_next     = nphys_reg;
        tmp_next       = tmp_reg;
        cnt_next       = cnt_reg;
        status_next    = status_reg;
        ltk_next       = ltk_reg;
        mem_we         = 1'b0;
        mem_wdata      = '{logical: in_elog, physical: in_ephy};
        alu_req        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    emit_kind_next = EMIT_STATUS;
                    status_next    = STATUS_OK;
                    segs_next      = '0;
                    idx_next       = '0;
                    room_next      = in_room_clamp;
                    klim_next      = in_klim;
                    start_next     = '0;
                    len_next       = '0;
                    unique case (in_op)
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        OP_APPEND: begin
                            if (table_full) begin
                                status_next = STATUS_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_READ: begin
                            start_next = in_start;
                            len_next   = in_len;
                        end
                        default: begin
                            status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            // look for the entry covering the start
            ST_SCAN: begin
                alu_req = '{a: start_reg, b: rd_entry_reg.logical, sub: 1'b1};
                if (alu_rsp.zero) begin
                    idx_next = idx_reg;
                end else if (alu_rsp.borrow) begin
                    if (idx_reg == '0) begin
                        status_next = STATUS_BELOW;
                    end else begin
                        idx_next = idx_reg - 1'b1;
                    end
                end else if (idx_inc != count_reg) begin
                    idx_next = idx_inc;
                end
            end
            // offset of the start into the covering extent
            ST_SEG_INIT: begin
                alu_req   = '{a: start_reg, b: rd_entry_reg.logical, sub: 1'b1};
                tmp_next  = alu_rsp.sum;
                phys_next = rd_entry_reg.physical;
            end
            ST_SEG_OFF: begin
                alu_req = '{a: phys_reg, b: tmp_reg, sub: 1'b0};
                if (phys_reg != '0) begin
                    phys_next = alu_rsp.sum;
                end
                idx_next       = idx_inc;
                emit_kind_next = EMIT_SEG;
            end
            // span up to the next entry, whole length when out of order
            ST_SEG_SPAN: begin
                alu_req    = '{a: rd_entry_reg.logical, b: start_reg, sub: 1'b1};
                tmp_next   = alu_rsp.borrow ? len_reg : alu_rsp.sum;
                nphys_next = rd_entry_reg.physical;
            end
            // clamp span by the remaining length
            ST_CNT: begin
                alu_req  = '{a: len_reg, b: tmp_reg, sub: 1'b1};
                cnt_next = alu_rsp.borrow ? len_reg : tmp_reg;
            end
            ST_ADV: begin
                alu_req    = '{a: start_reg, b: cnt_reg, sub: 1'b0};
                start_next = alu_rsp.sum;
            end
            ST_REM: begin
                alu_req  = '{a: len_reg, b: cnt_reg, sub: 1'b1};
                len_next = alu_rsp.sum;
            end
            ST_KCMP: begin
                alu_req  = '{a: start_reg, b: klim_reg, sub: 1'b1};
                ltk_next = alu_rsp.borrow;
            end
            ST_HOLE_CHECK: begin
                alu_req = '{a: start_reg, b: klim_reg, sub: 1'b1};
                if (alu_rsp.borrow && len_nz) begin
                    emit_kind_next = EMIT_HOLE;
                end
            end
            ST_HOLE_SPAN: begin
                alu_req        = '{a: klim_reg, b: start_reg, sub: 1'b1};
                tmp_next       = alu_rsp.sum;
                emit_kind_next = EMIT_HOLE;
            end
            // hand the result to the output register and step on
            ST_EMIT: begin
                if (out_load && emit_kind_reg == EMIT_SEG) begin
                    segs_next = segs_inc;
                    phys_next = nphys_reg;
                    idx_next  = idx_inc;
                    if (!loop_more && hole_more) begin
                        emit_kind_next = EMIT_HOLE;
                    end
                end
            end
            default: begin
                idx_next = idx_reg;
            end
        endcase
    end

    // output register contents
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
            case (emit_kind_reg)
                EMIT_SEG: begin
                    m_data_next = {len_reg, start_reg, phys_reg, cnt_reg};
                    m_user_next = {STATUS_OK, (phys_reg == '0), 1'b1};
                    m_last_next = !(loop_more || hole_more);
                end
                EMIT_HOLE: begin
                    m_data_next = {len_reg, start_reg, {ADDR_W{1'b0}}, cnt_reg};
                    m_user_next = {STATUS_OK, 1'b1, 1'b1};
                    m_last_next = 1'b1;
                end
                default: begin
                    m_data_next = {len_reg, start_reg, {(2 * ADDR_W){1'b0}}};
                    m_user_next = {status_reg, 1'b0, 1'b0};
                    m_last_next = 1'b1;
                end
            endcase
        end
    end

    // extent memory, read address follows the next index
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            extent_mem[count_reg[IDX_W-1:0]] <= mem_wdata;
        end
        rd_entry_reg <= extent_mem[idx_next[IDX_W-1:0]];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        emit_kind_reg <= emit_kind_next;
        idx_reg       <= idx_next;
        segs_reg      <= segs_next;
        room_reg      <= room_next;
        start_reg     <= start_next;
        len_reg       <= len_next;
        klim_reg      <= klim_next;
        phys_reg      <= phys_next;
        nphys_reg     <= nphys_next;
        tmp_reg       <= tmp_next;
        cnt_reg       <= cnt_next;
        status_reg    <= status_next;
        ltk_reg       <= ltk_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
        m_last_reg    <= m_last_next;
    end

    // checks on the sequencer
    `EMR_ASSERT_NXT(a_append_count, aclk, aresetn,
        in_fire && in_op == OP_APPEND && !table_full,
        count_reg == $past(count_reg) + 1'b1, "append did not advance the entry count")
    `EMR_ASSERT_IMP(a_read_in_range, aclk, aresetn,
        state_reg == ST_SCAN || state_reg == ST_SEG_INIT || state_reg == ST_SEG_SPAN,
        idx_reg < count_reg, "table read beyond the entry count")
    `EMR_ASSERT_IMP(a_segment_room, aclk, aresetn,
        state_reg == ST_SEG_SPAN || state_reg == ST_HOLE_SPAN,
        segs_reg < room_reg, "segment started without room")
    `EMR_ASSERT_NXT(a_final_beat, aclk, aresetn,
        out_load && emit_kind_reg != EMIT_SEG,
        state_reg == ST_IDLE && m_axis_tvalid && m_axis_tlast, "closing result not marked last")

endmodule

`default_nettype wire

FILE: bench/tb.sv
// self-checking bench for extent_map_read: drives clear, append and read beats
// and checks every result beat against an in-bench prediction of the table
// depends on emr_pkg and the extent_map_read rtl only
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import emr_pkg::*;

    localparam int    DEPTH      = TABLE_DEPTH_DEF;
    localparam int    SEG_CAP    = MAX_SEGMENTS_DEF;
    localparam addr_t ADDR_MAX   = {ADDR_W{1'b1}};
    localparam int    IDLE_LIMIT = 4000;
    localparam int    HOLD_AFTER = 60;
    localparam int    HOLD_LEN   = 400;
    localparam int    RANDOM_ITEMS = 36;
    // undefined operation code, answered with a plain status beat
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // one input beat, split into its fields
    typedef struct {
        logic [OP_W-1:0]   op;
        addr_t             ent_logical;
        addr_t             ent_physical;
        addr_t             start;
        addr_t             len;
        addr_t             leaf_bound;
        logic [ROOM_W-1:0] room;
    } request_t;

    // one result beat, split into its fields
    typedef struct {
        bit      seg_valid;
        addr_t   seg_len;
        addr_t   seg_block;
        bit      hole_flag;
        status_t status;
        addr_t   next_start;
        addr_t   remaining;
        bit      is_last;
    } seg_beat_t;

    // extent table copy plus the queue of segment beats still owed by the block
    class extent_table_board;
        addr_t       tbl_logical[DEPTH];
        addr_t       tbl_physical[DEPTH];
        int unsigned tbl_count;
        seg_beat_t   awaited[$];
        int unsigned failures;
        int unsigned requests_taken;
        int unsigned reads_taken;
        int unsigned beats_checked;
        int unsigned longest_read;

        function new();
            tbl_count = 0;
            failures = 0;
            requests_taken = 0;
            reads_taken = 0;
            beats_checked = 0;
            longest_read = 0;
        endfunction

        function void note_beat(bit v, addr_t len, addr_t blk, bit hole, status_t st,
                                addr_t ns, addr_t rem, bit is_last);
            seg_beat_t b;
            b.seg_valid = v;
            b.seg_len = len;
            b.seg_block = blk;
            b.hole_flag = hole;
            b.status = st;
            b.next_start = ns;
            b.remaining = rem;
            b.is_last = is_last;
            awaited.push_back(b);
        endfunction

        // walk the extents from the covering entry, then fill a hole to the key limit
        function void predict_read(request_t r);
            addr_t       at, left, phys, nl, span, cnt;
            int unsigned room, idx, segs;
            at = r.start;
            left = r.len;
            room = r.room;
            segs = 0;
            if (room > SEG_CAP) room = SEG_CAP;
            if (room == 0) begin
                note_beat(0, '0, '0, 0, STATUS_OK, at, left, 1);
                return;
            end
            // first equal entry wins, else the last one below the start
            idx = tbl_count;
            for (int i = 0; i < tbl_count; i++) begin
                if (at == tbl_logical[i]) begin
                    idx = i;
                    break;
                end
                if (at < tbl_logical[i]) begin
                    if (i == 0) begin
                        note_beat(0, '0, '0, 0, STATUS_BELOW, at, left, 1);
                        return;
                    end
                    idx = i - 1;
                    break;
                end
            end
            if (idx + 1 < tbl_count) begin
                phys = tbl_physical[idx];
                if (phys != '0) phys = phys + at - tbl_logical[idx];
                idx++;
                do begin
                    nl = tbl_logical[idx];
                    // out of order neighbour: run for the whole remainder
                    span = (nl >= at) ? nl - at : left;
                    cnt = (left < span) ? left : span;
                    at = at + cnt;
                    left = left - cnt;
                    note_beat(1, cnt, phys, phys == '0, STATUS_OK, at, left, 0);
                    phys = tbl_physical[idx];
                    segs++;
                    idx++;
                end while (left != '0 && segs < room && idx < tbl_count);
            end
            if (at < r.leaf_bound && left != '0 && segs < room) begin
                span = r.leaf_bound - at;
                cnt = (left < span) ? left : span;
                at = at + cnt;
                left = left - cnt;
                note_beat(1, cnt, '0, 1, STATUS_OK, at, left, 0);
                segs++;
            end
            if (segs == 0)
                note_beat(0, '0, '0, 0, STATUS_OK, at, left, 1);
            else
                awaited[awaited.size() - 1].is_last = 1'b1;
            if (segs > longest_read) longest_read = segs;
        endfunction

        // called once per accepted input beat
        function void take_request(request_t r);
            requests_taken++;
            case (r.op)
                OP_CLEAR: begin
                    tbl_count = 0;
                    note_beat(0, '0, '0, 0, STATUS_OK, '0, '0, 1);
                end
                OP_APPEND: begin
                    if (tbl_count >= DEPTH) begin
                        note_beat(0, '0, '0, 0, STATUS_FULL, '0, '0, 1);
                    end else begin
                        tbl_logical[tbl_count] = r.ent_logical;
                        tbl_physical[tbl_count] = r.ent_physical;
                        tbl_count++;
                        note_beat(0, '0, '0, 0, STATUS_OK, '0, '0, 1);
                    end
                end
                OP_READ: begin
                    reads_taken++;
                    predict_read(r);
                end
                default: note_beat(0, '0, '0, 0, STATUS_OK, '0, '0, 1);
            endcase
        endfunction

        function void compare_field(string name, logic [ADDR_W-1:0] want,
                                    logic [ADDR_W-1:0] got);
            if (got !== want) begin
                failures++;
                if (failures <= 20)
                    $display("%0t: %s mismatch: expected %0h, actual %0h",
                             $time, name, want, got);
            end
        endfunction

        // called once per accepted result beat
        function void check_beat(seg_beat_t got);
            seg_beat_t want;
            beats_checked++;
            if (awaited.size() == 0) begin
                failures++;
                if (failures <= 20)
                    $display({"%0t: result beat with nothing awaited: expected none, ",
                              "actual len %0h block %0h"},
                             $time, got.seg_len, got.seg_block);
                return;
            end
            want = awaited.pop_front();
            compare_field("seg_valid", want.seg_valid, got.seg_valid);
            compare_field("seg_length", want.seg_len, got.seg_len);
            compare_field("seg_block", want.seg_block, got.seg_block);
            compare_field("hole_flag", want.hole_flag, got.hole_flag);
            compare_field("status", want.status, got.status);
            compare_field("next_start", want.next_start, got.next_start);
            compare_field("remaining_length", want.remaining, got.remaining);
            compare_field("last", want.is_last, got.is_last);
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [S_TUSER_W-1:0] s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;
    logic                 m_axis_tlast;

    extent_table_board sb = new();

    addr_t       seq_logical[$];
    int unsigned items_sent = 0;
    int unsigned burst_left = 1;
    int unsigned idle_cycles = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 0;
    int unsigned rx_mode = 0;
    int unsigned rx_mode_left = 0;
    int unsigned rx_phase = 0;

    extent_map_read dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic addr_t rand_addr();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[ADDR_W-1:0];
    endfunction

    // lengths and offsets spread over small, medium and full range
    function automatic addr_t rand_span();
        case ($urandom_range(0, 3))
            0: return addr_t'($urandom_range(0, 8));
            1: return addr_t'($urandom_range(0, 1000));
            2: return addr_t'($urandom_range(0, 1 << 20));
            default: return rand_addr();
        endcase
    endfunction

    function automatic logic [ROOM_W-1:0] rand_room();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return ROOM_W'($urandom_range(1, 4));
            2: return ROOM_W'(SEG_CAP);
            3: return ROOM_W'($urandom_range(SEG_CAP + 1, 127));
            default: return ROOM_W'($urandom_range(1, SEG_CAP));
        endcase
    endfunction

    // offer one beat and hold it until taken; bursts end in a random gap
    task automatic send_request(input request_t r);
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= r.op;
        s_axis_tdata <= {1'b0, r.room, r.leaf_bound, r.len, r.start,
                         r.ent_physical, r.ent_logical};
        do @(posedge aclk); while (!s_axis_tready);
        sb.take_request(r);
        items_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // unused fields carry random junk
    task automatic send_op(input logic [OP_W-1:0] op, input addr_t elog, input addr_t ephy,
                           input addr_t strt, input addr_t len, input addr_t klim,
                           input logic [ROOM_W-1:0] room);
        request_t r;
        r.op = op;
        r.ent_logical = elog;
        r.ent_physical = ephy;
        r.start = strt;
        r.len = len;
        r.leaf_bound = klim;
        r.room = room;
        send_request(r);
    endtask

    task automatic do_clear();
        send_op(OP_CLEAR, rand_addr(), rand_addr(), rand_addr(), rand_addr(), rand_addr(),
                ROOM_W'($urandom_range(0, 127)));
    endtask

    task automatic do_append(input addr_t lg, input addr_t ph);
        send_op(OP_APPEND, lg, ph, rand_addr(), rand_addr(), rand_addr(),
                ROOM_W'($urandom_range(0, 127)));
    endtask

    task automatic do_read(input addr_t strt, input addr_t len, input addr_t klim,
                           input logic [ROOM_W-1:0] room);
        send_op(OP_READ, rand_addr(), rand_addr(), strt, len, klim, room);
    endtask

    // clear, then a sorted table ending in a hole sentinel
    task automatic load_table(input int unsigned n);
        addr_t lg, ph;
        seq_logical.delete();
        do_clear();
        case ($urandom_range(0, 3))
            0: lg = '0;
            1: lg = addr_t'($urandom_range(0, 1000));
            2: lg = rand_addr() >> 2;
            default: lg = ADDR_MAX - addr_t'(1 << 30);
        endcase
        for (int i = 0; i < n; i++) begin
            if (i > 0) begin
                case ($urandom_range(0, 5))
                    0: lg = lg;
                    1, 2: lg = lg + addr_t'($urandom_range(1, 16));
                    default: lg = lg + addr_t'($urandom_range(1, 1 << 20));
                endcase
            end
            if (i == n - 1 || $urandom_range(0, 3) == 0)
                ph = '0;
            else
                ph = ($urandom_range(0, 1) == 0) ? addr_t'($urandom_range(1, 1 << 16))
                                                 : rand_addr();
            do_append(lg, ph);
            seq_logical.push_back(lg);
        end
    endtask

    // read starting near the loaded extents most of the time
    task automatic random_read();
        addr_t strt, klim, top;
        int unsigned n;
        n = seq_logical.size();
        top = (n > 0) ? seq_logical[n-1] : '0;
        if (n == 0) begin
            strt = rand_addr();
        end else begin
            case ($urandom_range(0, 6))
                0, 1: strt = seq_logical[$urandom_range(0, n - 1)];
                2, 3: strt = seq_logical[$urandom_range(0, n - 1)] + rand_span();
                4: strt = seq_logical[0] - addr_t'($urandom_range(1, 50));
                5: strt = top + rand_span();
                default: strt = rand_addr();
            endcase
        end
        case ($urandom_range(0, 3))
            0: klim = rand_addr();
            1: klim = strt;
            default: klim = top + rand_span();
        endcase
        do_read(strt, rand_span(), klim, rand_room());
    endtask

    // full-size table: long scans, longest reads and appends past the end
    task automatic fill_table();
        addr_t lg;
        seq_logical.delete();
        do_clear();
        lg = addr_t'($urandom_range(0, 1000));
        for (int i = 0; i < DEPTH; i++) begin
            do_append(lg, (i == DEPTH - 1 || $urandom_range(0, 3) == 0) ? addr_t'(0)
                                                                         : rand_addr());
            seq_logical.push_back(lg);
            lg = lg + addr_t'($urandom_range(1, 64));
        end
        do_append(lg, rand_addr());
        do_append(rand_addr(), rand_addr());
        do_read(seq_logical[0], ADDR_MAX, ADDR_MAX, ROOM_W'(SEG_CAP));
        do_read(seq_logical[DEPTH-6] + 1, ADDR_MAX, lg + 100, ROOM_W'(127));
        do_read(seq_logical[DEPTH-1], 1000, lg + 100, ROOM_W'(8));
        repeat (6) random_read();
        do_clear();
        do_read(rand_addr(), rand_span(), ADDR_MAX, ROOM_W'(4));
    endtask

    // stimulus
    initial begin
        aresetn <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table gives a plain hole
        do_read(5, 10, 100, 4);
        // small table with a hole, equal neighbours, a wrapping offset and a sentinel
        do_clear();
        do_append(10, 1000);
        do_append(20, 0);
        do_append(20, 777);
        do_append(30, ADDR_MAX);
        do_append(40, 0);
        do_read(10, 100, 60, 64);
        do_read(5, 3, 60, 8);
        do_read(35, 3, 60, 8);
        do_read(15, 0, 60, 8);
        do_read(10, 100, 60, 0);
        do_read(10, 100, 60, 127);
        do_read(10, 100, 60, 1);
        do_read(50, 10, 45, 8);
        do_read(20, 5, 60, 8);
        do_read(ADDR_MAX, ADDR_MAX, ADDR_MAX, 64);
        do_read(12, ADDR_MAX, 0, 64);
        send_op(OP_UNUSED, rand_addr(), rand_addr(), rand_addr(), rand_addr(), rand_addr(),
                ROOM_W'($urandom_range(0, 127)));

        // random: mostly sorted tables with reads, some noise and broken tables
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) != 0) begin
                load_table(($urandom_range(0, 7) == 0) ? $urandom_range(17, 40)
                                                       : $urandom_range(1, 16));
                repeat ($urandom_range(2, 8)) random_read();
            end else begin
                repeat ($urandom_range(1, 3)) do_append(rand_addr(), rand_span());
                send_op(2'($urandom_range(0, 3)), rand_addr(), rand_addr(), rand_addr(),
                        rand_addr(), rand_addr(), ROOM_W'($urandom_range(0, 127)));
                repeat ($urandom_range(1, 3)) random_read();
            end
        end
        fill_table();

        @(posedge aclk);
        s_axis_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("covered %0d requests with %0d reads and %0d result beats",
                 sb.requests_taken, sb.reads_taken, sb.beats_checked);
        $display("longest read gave %0d segments; table filled to %0d entries",
                 sb.longest_read, DEPTH);
        if (sb.failures == 0 && sb.awaited.size() == 0) begin
            $display("extent_map_read test passed");
        end else begin
            $display("extent_map_read test failed");
        end
        $finish;
    end

    // result side: check each beat, then pick the next ready value
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_beat('{seg_valid: m_axis_tuser[0],
                            seg_len: m_axis_tdata[ADDR_W-1:0],
                            seg_block: m_axis_tdata[2*ADDR_W-1:ADDR_W],
                            hole_flag: m_axis_tuser[1],
                            status: status_t'(m_axis_tuser[3:2]),
                            next_start: m_axis_tdata[3*ADDR_W-1:2*ADDR_W],
                            remaining: m_axis_tdata[4*ADDR_W-1:3*ADDR_W],
                            is_last: m_axis_tlast});
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && sb.requests_taken >= HOLD_AFTER) begin
            // one long hold-off so the block backs up onto its input
            hold_done = 1;
            hold_left = HOLD_LEN;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(32, 256);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= (rx_phase % 4) != 3;
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
            rx_phase++;
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
            $display("extent_map_read test failed");
            $finish;
        end
    end

endmodule

`default_nettype wire

FILE: files.f
+incdir+design
design/emr_pkg.sv
design/emr_alu.sv
design/extent_map_read.sv
bench/tb.sv
